### sv/spq_pkg.sv
// Package for the sorted priority queue.
// Holds the opcode and status codes, the default depth and the command struct
// that is shared by the queue cells. It depends on nothing else.
package spq_pkg;

	localparam int SPQ_DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int COUNT_OUT_W = 7;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} spq_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [KEY_W-1:0]  key;
	} spq_cmd_t;

endpackage

### sv/spq_cell.sv
// One cell of the sorted priority queue: holds one key and trades it with
// its neighbors on insert and remove. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
	parameter int IDX = 0,
	parameter int CNT_W = 7
) (
	input  logic              clk,
	input  spq_cmd_t          cmd,
	input  logic [CNT_W-1:0]  count,
	input  logic [KEY_W-1:0]  left_key,
	input  logic              left_gt,
	input  logic [KEY_W-1:0]  right_key,
	output logic [KEY_W-1:0]  key,
	output logic              gt
);

	localparam logic [CNT_W-1:0] Idx = CNT_W'(IDX);

	logic [KEY_W-1:0] key_q;
	logic             occ;
	logic             at_end;

	assign occ = Idx < count;
	assign at_end = Idx == count;
	assign gt = occ && ($signed(key_q) > $signed(cmd.key));
	assign key = key_q;

	// The key register holds payload only; occupancy follows from the fill count.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_gt) begin
				key_q <= left_key;
			end else if (gt || at_end) begin
				key_q <= cmd.key;
			end
		end else if (cmd.rem) begin
			key_q <= right_key;
		end
	end

endmodule

### sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a row of spq_cell instances, the
// fill count and the result register. Depends on spq_pkg and spq_cell.
//
//  channel  | direction | tdata                          | tuser
//  s_*      | in        | value[31:0]                    | opcode
//  m_*      | out       | removed_value[31:0], count     | status
//
// All cells compare against the new key in parallel and shift by one place
// in the same edge, so a request is taken in every cycle while the result
// register is empty or being drained.
// The asynchronous reset empties the queue; the key cells are not cleared.
// A stall on m_tready holds the result register and stops input.
module sorted_priority_queue_core import spq_pkg::*; #(
	parameter int DEPTH = SPQ_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic        s_tuser,   // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // removed_value[31:0], count[38:32], zero[39]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [CntW-1:0] Full = CntW'(DEPTH);

	logic [CntW-1:0]  fill_q;
	logic [CntW-1:0]  fill_d;
	logic             out_valid_q;
	logic [KEY_W-1:0] out_key_q;
	logic [1:0]       out_status_q;
	logic [CntW-1:0]  out_count_q;

	logic             accept;
	logic             is_full;
	logic             is_empty;
	spq_cmd_t         cmd;
	logic [KEY_W-1:0] res_key;
	spq_status_t      res_status;

	logic [KEY_W-1:0] keys [DEPTH];
	logic             gts  [DEPTH];

	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign is_full = fill_q == Full;
	assign is_empty = fill_q == '0;

	always_comb begin
		cmd.ins = accept && (s_tuser == OP_INSERT) && !is_full;
		cmd.rem = accept && (s_tuser == OP_REMOVE) && !is_empty;
		cmd.key = s_tdata;
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [KEY_W-1:0] lk;
			logic             lg;
			logic [KEY_W-1:0] rk;
			if (i == 0) begin : g_first
				assign lk = '0;
				assign lg = 1'b0;
			end else begin : g_mid
				assign lk = keys[i-1];
				assign lg = gts[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign rk = '0;
			end else begin : g_inner
				assign rk = keys[i+1];
			end
			spq_cell #(
				.IDX   (i),
				.CNT_W (CntW)
			) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.count     (fill_q),
				.left_key  (lk),
				.left_gt   (lg),
				.right_key (rk),
				.key       (keys[i]),
				.gt        (gts[i])
			);
		end
	endgenerate

	always_comb begin
		fill_d = fill_q;
		res_key = '0;
		res_status = ST_OK;
		if (s_tuser == OP_INSERT) begin
			if (is_full) begin
				res_status = ST_FULL;
			end else begin
				fill_d = fill_q + CntW'(1);
			end
		end else begin
			if (is_empty) begin
				res_key = '1;
				res_status = ST_EMPTY;
			end else begin
				res_key = keys[0];
				fill_d = fill_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_key_q <= res_key;
			out_status_q <= res_status;
			out_count_q <= fill_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, COUNT_OUT_W'(out_count_q), out_key_q};
	assign m_tuser = out_status_q;

endmodule
